@@ rtl/aesgcm_pkg.sv @@
// Package: codes, field widths, S-box and helper functions for the AES-256-GCM core.
package aesgcm_pkg;

    localparam int KeyWords = 4;
    localparam int RkDepth  = 30;
    localparam int RkAddrW  = 5;
    localparam int CfgIdxW  = 2;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_ORDER    = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_OPEN = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    localparam logic [127:0] GF_REDUCE = {64'he100000000000000, 64'h0};

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // bytes are numbered from the top: byte 0 in bits 127:120
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [127:0] o;
        logic [7:0] a, b, d, e;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[c*4+i] = sbox(s[127 - 8*(((c+i)%4)*4+i) -: 8]);
        for (int c = 0; c < 4; c++) begin
            a = t[c*4]; b = t[c*4+1]; d = t[c*4+2]; e = t[c*4+3];
            if (last) begin
                o[127-8*(c*4)   -: 8] = a;
                o[127-8*(c*4+1) -: 8] = b;
                o[127-8*(c*4+2) -: 8] = d;
                o[127-8*(c*4+3) -: 8] = e;
            end else begin
                o[127-8*(c*4)   -: 8] = xt(a) ^ xt(b) ^ b ^ d ^ e;
                o[127-8*(c*4+1) -: 8] = a ^ xt(b) ^ xt(d) ^ d ^ e;
                o[127-8*(c*4+2) -: 8] = a ^ b ^ xt(d) ^ xt(e) ^ e;
                o[127-8*(c*4+3) -: 8] = xt(a) ^ a ^ b ^ d ^ xt(e);
            end
        end
        return o;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] rcon(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd1: r = 8'h01; 3'd2: r = 8'h02; 3'd3: r = 8'h04; 3'd4: r = 8'h08;
            3'd5: r = 8'h10; 3'd6: r = 8'h20; 3'd7: r = 8'h40;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/aes256_gcm_authenticated_cipher_core.sv @@
// Top level of the AES-256-GCM core: sequencer, round-key memory, AES round unit.
// Data item: the result follows 14 rounds, each with two 64-bit round-key reads;
// the GHASH fold follows, and the next input is taken only once that fold is done.
// Begin item: key expansion, then E(0) and E(J0). End item: the length block is folded, then the tag.
// Out-of-order and empty items: the result goes out through the S_OUT state. One item is worked at a time.
// Reset (aresetn low, synchronous) clears control, phase, counters, accumulator and key.
module aes256_gcm_authenticated_cipher_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // data_high, data_low, valid_bytes, zero fill
    input  logic [2:0]   s_tuser,   // mode, decrypt
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // result_high, result_low, result_bytes, status, zero fill
    output logic         m_tlast,   // end_of_message
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [aesgcm_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [63:0]  cfg_data
);
    import aesgcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_KX_RD, S_KX_WAIT, S_KX_WR, S_C_START, S_C_RD, S_C_RUN,
        S_C_LAST, S_DATA_FIN, S_END_WAIT, S_END_FIN, S_OUT
    } state_t;

    typedef enum logic [1:0] { J_HASH, J_MASK, J_DATA } job_t;

    state_t state_reg;
    job_t   job_reg;

    logic [63:0]  key_reg [KeyWords];
    logic [63:0]  rk_mem [RkDepth];
    logic [63:0]  rk_rd_reg;
    logic [RkAddrW-1:0] rk_raddr;
    logic         rk_we;
    logic [RkAddrW-1:0] rk_waddr;
    logic [63:0]  rk_wdata;

    // 8-word sliding window of the key schedule
    logic [31:0]  w_reg [8];
    logic [5:0]   wi_reg;
    logic [3:0]   rnd_reg;
    logic         half_reg;
    logic [127:0] s_reg;
    logic [63:0]  rk_hi_reg;

    logic [127:0] hkey_reg, tmask_reg, acc_reg, blk_reg, ks_in_reg;
    logic [63:0]  nonce_hi_reg;
    logic [31:0]  nonce_lo_reg, ctr_reg;
    logic [60:0]  total_reg;
    logic         dir_reg;
    logic [1:0]   phase_reg;
    logic [4:0]   nb_reg;
    logic [127:0] mask_reg;

    logic         out_v_reg;
    logic [127:0] out_d_reg;
    logic [4:0]   out_n_reg;
    logic [1:0]   out_s_reg;
    logic         out_l_reg;

    logic         gh_start, gh_busy;
    logic [127:0] gh_x, gh_z;
    logic         gh_pend_reg;

    logic [1:0]   in_mode;
    logic         in_dec;
    logic [127:0] in_blk;
    logic [4:0]   in_nb;
    logic [4:0]   nb_sat;
    logic [127:0] nb_mask;

    assign in_mode = s_tuser[1:0];
    assign in_dec  = s_tuser[2];
    assign in_blk  = {s_tdata[63:0], s_tdata[127:64]};
    assign in_nb   = s_tdata[132:128];
    assign nb_sat  = (in_nb > 5'd16) ? 5'd16 : in_nb;
    always_comb begin
        for (int i = 0; i < 16; i++)
            nb_mask[127-8*i -: 8] = (5'(i) < nb_sat) ? 8'hff : 8'h00;
    end

    assign s_tready  = (state_reg == S_IDLE) && !out_v_reg && !gh_busy && !gh_pend_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KeyWords; i++) key_reg[i] <= 64'h0;
        end else if (cfg_valid && cfg_ready) begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // key schedule word
    logic [31:0] kx_t, kx_w;
    always_comb begin
        kx_t = w_reg[7];
        if (wi_reg[2:0] == 3'd0)
            kx_t = sub_word({kx_t[23:0], kx_t[31:24]}) ^ {rcon(wi_reg[5:3]), 24'h0};
        else if (wi_reg[2:0] == 3'd4)
            kx_t = sub_word(kx_t);
        kx_w = w_reg[0] ^ kx_t;
    end

    logic [127:0] rk_full;
    assign rk_full = {rk_hi_reg, rk_rd_reg};

    always_ff @(posedge aclk) begin
        if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
        rk_rd_reg <= rk_mem[rk_raddr];
    end

    always_comb begin
        rk_we    = 1'b0;
        rk_waddr = wi_reg[RkAddrW:1];
        rk_wdata = {w_reg[6], w_reg[7]};
        rk_raddr = {rnd_reg, half_reg};
        if (state_reg == S_KX_RD)
            rk_wdata = {w_reg[{wi_reg[2:1], 1'b0}], w_reg[{wi_reg[2:1], 1'b1}]};
        if (state_reg == S_KX_RD && wi_reg < 6'd8 && wi_reg[0]) rk_we = 1'b1;
        if (state_reg == S_KX_WR && wi_reg[0]) rk_we = 1'b1;
    end

    logic [127:0] dout;
    assign dout = (blk_reg ^ s_reg) & mask_reg;

    assign gh_x = (state_reg == S_END_WAIT) ? (acc_reg ^ {64'h0, total_reg, 3'b000})
                                            : (acc_reg ^ (dir_reg ? blk_reg : dout));
    assign gh_start = (state_reg == S_DATA_FIN && job_reg == J_DATA)
                   || (state_reg == S_END_WAIT && !gh_busy);

    aesgcm_ghash u_ghash (
        .aclk(aclk), .aresetn(aresetn), .start(gh_start),
        .x(gh_x), .h(hkey_reg), .busy(gh_busy), .z(gh_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            out_v_reg   <= 1'b0;
            phase_reg   <= PH_IDLE;
            acc_reg     <= 128'h0;
            nonce_hi_reg <= 64'h0;
            nonce_lo_reg <= 32'h0;
            ctr_reg     <= 32'd2;
            total_reg   <= 61'h0;
            dir_reg     <= 1'b0;
            gh_pend_reg <= 1'b0;
            job_reg     <= J_HASH;
            wi_reg      <= 6'd0;
            rnd_reg     <= 4'd0;
            half_reg    <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) out_v_reg <= 1'b0;
            if (gh_pend_reg && !gh_busy) begin
                acc_reg     <= gh_z;
                gh_pend_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        out_d_reg <= 128'h0;
                        out_n_reg <= 5'd0;
                        out_s_reg <= ST_OK;
                        out_l_reg <= 1'b0;
                        case (in_mode)
                            MODE_BEGIN: begin
                                dir_reg      <= in_dec;
                                nonce_hi_reg <= in_blk[127:64];
                                nonce_lo_reg <= in_blk[63:32];
                                for (int i = 0; i < 8; i++)
                                    w_reg[i] <= key_reg[i/2][63-32*(i%2) -: 32];
                                wi_reg       <= 6'd1;
                                state_reg    <= S_KX_RD;
                            end
                            MODE_DATA: begin
                                if (phase_reg != PH_OPEN) begin
                                    out_s_reg <= ST_ORDER;
                                    state_reg <= S_OUT;
                                end else if (nb_sat == 5'd0) begin
                                    state_reg <= S_OUT;
                                end else begin
                                    blk_reg   <= in_blk & nb_mask;
                                    mask_reg  <= nb_mask;
                                    nb_reg    <= nb_sat;
                                    ks_in_reg <= {nonce_hi_reg, nonce_lo_reg, ctr_reg};
                                    job_reg   <= J_DATA;
                                    state_reg <= S_C_START;
                                end
                            end
                            MODE_END: begin
                                out_l_reg <= 1'b1;
                                blk_reg   <= in_blk;
                                if (phase_reg == PH_IDLE) begin
                                    out_s_reg <= ST_ORDER;
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_END_WAIT;
                                end
                            end
                            default: begin
                                out_s_reg <= ST_ORDER;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                // first 8 words are the key itself; written two per pass
                S_KX_RD: begin
                    if (wi_reg < 6'd8) begin
                        wi_reg <= wi_reg + 6'd1;
                        if (wi_reg == 6'd7) begin
                            wi_reg    <= 6'd8;
                            state_reg <= S_KX_WAIT;
                        end
                    end else begin
                        state_reg <= S_KX_WAIT;
                    end
                end
                S_KX_WAIT: begin
                    for (int i = 0; i < 7; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[7]  <= kx_w;
                    state_reg <= S_KX_WR;
                end
                S_KX_WR: begin
                    if (wi_reg == 6'd59) begin
                        ks_in_reg <= 128'h0;
                        job_reg   <= J_HASH;
                        state_reg <= S_C_START;
                    end else begin
                        wi_reg    <= wi_reg + 6'd1;
                        state_reg <= S_KX_WAIT;
                    end
                end
                S_C_START: begin
                    rnd_reg   <= 4'd0;
                    half_reg  <= 1'b0;
                    state_reg <= S_C_RD;
                end
                S_C_RD: begin
                    half_reg  <= 1'b1;
                    state_reg <= S_C_RUN;
                end
                S_C_RUN: begin
                    if (!half_reg) begin
                        half_reg <= 1'b1;
                        if (rnd_reg == 4'd1)
                            s_reg <= ks_in_reg ^ rk_full;
                        else
                            s_reg <= aes_round(s_reg, 1'b0) ^ rk_full;
                    end else begin
                        rk_hi_reg <= rk_rd_reg;
                        half_reg  <= 1'b0;
                        if (rnd_reg == 4'd14) state_reg <= S_C_LAST;
                        else rnd_reg <= rnd_reg + 4'd1;
                    end
                end
                S_C_LAST: begin
                    s_reg     <= aes_round(s_reg, 1'b1) ^ rk_full;
                    state_reg <= S_DATA_FIN;
                end
                S_DATA_FIN: begin
                    case (job_reg)
                        J_HASH: begin
                            hkey_reg  <= s_reg;
                            ks_in_reg <= {nonce_hi_reg, nonce_lo_reg, 32'd1};
                            job_reg   <= J_MASK;
                            state_reg <= S_C_START;
                        end
                        J_MASK: begin
                            tmask_reg <= s_reg;
                            acc_reg   <= 128'h0;
                            ctr_reg   <= 32'd2;
                            total_reg <= 61'h0;
                            phase_reg <= PH_OPEN;
                            state_reg <= S_IDLE;
                        end
                        default: begin
                            out_d_reg <= dout;
                            out_n_reg <= nb_reg;
                            ctr_reg   <= ctr_reg + 32'd1;
                            total_reg <= total_reg + 61'(nb_reg);
                            if (nb_reg != 5'd16) phase_reg <= PH_TAIL;
                            gh_pend_reg <= 1'b1;
                            out_v_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_END_WAIT: begin
                    if (!gh_busy) state_reg <= S_END_FIN;
                end
                S_END_FIN: begin
                    if (!gh_busy) begin
                        if (dir_reg)
                            out_s_reg <= ((gh_z ^ tmask_reg) != blk_reg) ? ST_MISMATCH : ST_OK;
                        else begin
                            out_d_reg <= gh_z ^ tmask_reg;
                            out_n_reg <= 5'd16;
                        end
                        phase_reg <= PH_IDLE;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, out_s_reg, out_n_reg, out_d_reg[63:0], out_d_reg[127:64]};
    assign m_tlast  = out_l_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second item while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_s_reg != ST_ORDER || out_n_reg == 5'd0))
        else $error("order error result carries data");
    assert property (@(posedge aclk) disable iff (!aresetn)
        gh_start |-> !gh_busy)
        else $error("GHASH restarted while busy");
endmodule

@@ rtl/aesgcm_ghash.sv @@
// GF(2^128) multiplier for GHASH, eight bits of the multiplier per cycle.
module aesgcm_ghash (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] x,
    input  logic [127:0] h,
    output logic         busy,
    output logic [127:0] z
);
    import aesgcm_pkg::*;

    logic [127:0] a_reg, v_reg, z_reg;
    logic [4:0]   cnt_reg;
    logic [127:0] a_next, v_next, z_next;

    always_comb begin
        a_next = a_reg;
        v_next = v_reg;
        z_next = z_reg;
        for (int i = 0; i < 8; i++) begin
            if (a_next[127]) z_next = z_next ^ v_next;
            a_next = {a_next[126:0], 1'b0};
            v_next = {1'b0, v_next[127:1]} ^ (v_next[0] ? GF_REDUCE : 128'h0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 5'd0;
        end else if (start) begin
            cnt_reg <= 5'd16;
        end else if (cnt_reg != 5'd0) begin
            cnt_reg <= cnt_reg - 5'd1;
        end
        if (start) begin
            a_reg <= x;
            v_reg <= h;
            z_reg <= 128'h0;
        end else if (cnt_reg != 5'd0) begin
            a_reg <= a_next;
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

    assign busy = (cnt_reg != 5'd0);
    assign z    = z_reg;
endmodule

@@ tb/testbench.sv @@
// Testbench for the AES-256-GCM core: random and directed messages checked against a predictor.
`timescale 1ns / 100ps

class gcm_scoreboard;
    logic [63:0]  key_reg [4];
    logic [63:0]  rk [30];
    logic [127:0] hkey, tmask, acc;
    logic [63:0]  nonce_hi;
    logic [31:0]  nonce_lo, ctr;
    logic [60:0]  total;
    logic         dir;
    logic [1:0]   phase;
    logic [136:0] pending [$];   // {tlast, fill, status, bytes, data}
    int           errors;

    function void clear();
        foreach (key_reg[i]) key_reg[i] = 0;
        acc = 0; nonce_hi = 0; nonce_lo = 0; ctr = 2; total = 0; dir = 0;
        phase = aesgcm_pkg::PH_IDLE;
        pending.delete();
        errors = 0;
    endfunction

    function logic [7:0] sb(logic [7:0] a);
        logic [7:0] inv, x, y;
        // S-box from field inverse and affine map
        inv = 0;
        if (a != 0) begin
            for (int c = 1; c < 256; c++) begin
                if (gmul(a, c[7:0]) == 8'h01) inv = c[7:0];
            end
        end
        x = inv; y = inv;
        for (int k = 0; k < 4; k++) begin
            x = {x[6:0], x[7]};
            y = y ^ x;
        end
        return y ^ 8'h63;
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    logic [7:0] sbt [256];
    bit         sbt_ok;

    function logic [7:0] s(logic [7:0] a);
        if (!sbt_ok) begin
            for (int k = 0; k < 256; k++) sbt[k] = sb(k[7:0]);
            sbt_ok = 1;
        end
        return sbt[a];
    endfunction

    function void expand();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        for (int i = 0; i < 8; i++) w[i] = 32'(key_reg[i/2] >> (32 * (1 - i % 2)));
        rc = 8'h01;
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t = {s(t[23:16]) ^ rc, s(t[15:8]), s(t[7:0]), s(t[31:24])};
                rc = gmul(rc, 8'h02);
            end else if (i % 8 == 4) begin
                t = {s(t[31:24]), s(t[23:16]), s(t[15:8]), s(t[7:0])};
            end
            w[i] = w[i-8] ^ t;
        end
        for (int i = 0; i < 30; i++) rk[i] = {w[2*i], w[2*i+1]};
    endfunction

    function logic [127:0] encrypt_block(logic [127:0] b);
        logic [7:0] st [16];
        logic [7:0] t [16];
        logic [127:0] r;
        r = {rk[0], rk[1]};
        for (int i = 0; i < 16; i++) st[i] = b[127-8*i -: 8] ^ r[127-8*i -: 8];
        for (int rnd = 1; rnd <= 14; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[c*4+i] = s(st[((c+i)%4)*4+i]);
            for (int c = 0; c < 4; c++) begin
                if (rnd < 14) begin
                    st[c*4]   = gmul(t[c*4], 8'h02) ^ gmul(t[c*4+1], 8'h03)
                              ^ t[c*4+2] ^ t[c*4+3];
                    st[c*4+1] = t[c*4] ^ gmul(t[c*4+1], 8'h02)
                              ^ gmul(t[c*4+2], 8'h03) ^ t[c*4+3];
                    st[c*4+2] = t[c*4] ^ t[c*4+1] ^ gmul(t[c*4+2], 8'h02)
                              ^ gmul(t[c*4+3], 8'h03);
                    st[c*4+3] = gmul(t[c*4], 8'h03) ^ t[c*4+1] ^ t[c*4+2]
                              ^ gmul(t[c*4+3], 8'h02);
                end else begin
                    for (int i = 0; i < 4; i++) st[c*4+i] = t[c*4+i];
                end
            end
            r = {rk[2*rnd], rk[2*rnd+1]};
            for (int i = 0; i < 16; i++) st[i] ^= r[127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = st[i];
        return r;
    endfunction

    function void ghash(logic [127:0] x);
        logic [127:0] a, v, z;
        a = acc ^ x; v = hkey; z = 0;
        for (int i = 0; i < 128; i++) begin
            if (a[127]) z ^= v;
            a = a << 1;
            v = v[0] ? ((v >> 1) ^ aesgcm_pkg::GF_REDUCE) : (v >> 1);
        end
        acc = z;
    endfunction

    function void note_input(logic [1:0] mode, logic dec, logic [127:0] d, logic [4:0] vb);
        logic [127:0] mask, ks, o, tag;
        logic [4:0]   nb;
        logic [1:0]   st;
        case (mode)
            aesgcm_pkg::MODE_BEGIN: begin
                dir = dec; nonce_hi = d[127:64]; nonce_lo = d[63:32];
                expand();
                hkey = encrypt_block(128'h0);
                tmask = encrypt_block({nonce_hi, nonce_lo, 32'd1});
                acc = 0; ctr = 2; total = 0;
                phase = aesgcm_pkg::PH_OPEN;
            end
            aesgcm_pkg::MODE_DATA: begin
                if (phase != aesgcm_pkg::PH_OPEN) begin
                    pending.push_back({1'b0, 1'b0, aesgcm_pkg::ST_ORDER, 5'd0, 128'd0});
                end else begin
                    nb = (vb > 16) ? 5'd16 : vb;
                    if (nb == 0) begin
                        pending.push_back({1'b0, 1'b0, aesgcm_pkg::ST_OK, 5'd0, 128'd0});
                    end else begin
                        mask = ~(128'h0) << (128 - 8 * nb);
                        if (nb == 16) mask = ~(128'h0);
                        d &= mask;
                        ks = encrypt_block({nonce_hi, nonce_lo, ctr});
                        o = (d ^ ks) & mask;
                        ghash(dir ? d : o);
                        ctr++;
                        total += nb;
                        if (nb < 16) phase = aesgcm_pkg::PH_TAIL;
                        pending.push_back({1'b0, 1'b0, aesgcm_pkg::ST_OK, nb, o});
                    end
                end
            end
            aesgcm_pkg::MODE_END: begin
                if (phase == aesgcm_pkg::PH_IDLE) begin
                    pending.push_back({1'b1, 1'b0, aesgcm_pkg::ST_ORDER, 5'd0, 128'd0});
                end else begin
                    ghash({64'd0, total, 3'b0});
                    tag = acc ^ tmask;
                    if (dir) begin
                        st = (tag != d) ? aesgcm_pkg::ST_MISMATCH : aesgcm_pkg::ST_OK;
                        pending.push_back({1'b1, 1'b0, st, 5'd0, 128'd0});
                    end else begin
                        pending.push_back({1'b1, 1'b0, aesgcm_pkg::ST_OK, 5'd16, tag});
                    end
                    phase = aesgcm_pkg::PH_IDLE;
                end
            end
            default: pending.push_back({1'b0, 1'b0, aesgcm_pkg::ST_ORDER, 5'd0, 128'd0});
        endcase
    endfunction

    task report(string what, logic [135:0] got, logic [135:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task check_result(logic [135:0] data, logic last);
        logic [136:0] e;
        logic [127:0] got;
        if (pending.size() == 0) begin
            report("unexpected transaction", data, 0);
            return;
        end
        e = pending.pop_front();
        got = {data[63:0], data[127:64]};
        if (got != e[127:0]) report("data", got, e[127:0]);
        if (data[132:128] != e[132:128]) report("bytes", data[132:128], e[132:128]);
        if (data[134:133] != e[134:133]) report("status", data[134:133], e[134:133]);
        if (data[135] != 1'b0) report("fill", data, 0);
        if (last != e[136]) report("tlast", last, e[136]);
    endtask
endclass

module testbench;
    import aesgcm_pkg::*;

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [135:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid, m_tready;
    logic [135:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid, cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [63:0]  cfg_data;

    gcm_scoreboard sb_q;
    int send_idle, recv_stall;

    aes256_gcm_authenticated_cipher_core dut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #500ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb_q.check_result(m_tdata, m_tlast);
        if (!aresetn) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task write_key(int idx, logic [63:0] v);
        cfg_valid <= 1; cfg_index <= idx[CfgIdxW-1:0]; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb_q.key_reg[idx] = v;
        @(posedge aclk);
    endtask

    task send(logic [1:0] mode, logic dec, logic [127:0] d, logic [4:0] vb);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= {dec, mode};
        s_tdata <= {3'b0, vb, d[63:0], d[127:64]};
        do @(posedge aclk); while (!s_tready);
        sb_q.note_input(mode, dec, d, vb);
    endtask

    task drain();
        int n;
        n = 0;
        s_tvalid <= 0;
        while (sb_q.pending.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        repeat (200) @(posedge aclk);
    endtask

    function logic [127:0] rnd128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task message(logic dec, int blocks, bit tamper);
        logic [127:0] tag;
        int nb;
        logic [127:0] save;
        send(MODE_BEGIN, dec, rnd128(), 5'($urandom_range(31)));
        for (int i = 0; i < blocks; i++) begin
            nb = (i == blocks - 1) ? $urandom_range(31) : 16;
            send(MODE_DATA, 1'($urandom_range(1)), rnd128(), 5'(nb));
        end
        tag = rnd128();
        if (dec && !tamper) begin
            // compute the correct tag on a copy of the state
            save = sb_q.acc;
            sb_q.ghash({64'd0, sb_q.total, 3'b0});
            tag = sb_q.acc ^ sb_q.tmask;
            sb_q.acc = save;
        end
        send(MODE_END, 1'($urandom_range(1)), tag, 5'($urandom_range(31)));
    endtask

    initial begin
        int count;
        sb_q = new();
        sb_q.clear();
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        send_idle = 0; recv_stall = 0;
        aresetn = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: zero key, then all-ones key
        for (int i = 0; i < 4; i++) write_key(i, 64'd0);
        send(MODE_DATA, 1'b0, '1, 5'd16);
        send(MODE_END, 1'b0, '0, 5'd0);
        send(2'd3, 1'b1, '1, 5'd31);
        send(MODE_BEGIN, 1'b0, '0, 5'd0);
        send(MODE_DATA, 1'b0, '0, 5'd16);
        send(MODE_DATA, 1'b1, '1, 5'd31);
        send(MODE_DATA, 1'b0, '1, 5'd0);
        send(MODE_DATA, 1'b0, '1, 5'd5);
        send(MODE_DATA, 1'b0, '1, 5'd16);
        send(MODE_END, 1'b0, '0, 5'd0);
        send(MODE_BEGIN, 1'b1, '1, 5'd31);
        send(MODE_DATA, 1'b0, '1, 5'd8);
        send(MODE_END, 1'b1, '1, 5'd0);
        drain();
        for (int i = 0; i < 4; i++) write_key(i, '1);
        message(1'b0, 2, 1'b0);
        message(1'b1, 2, 1'b0);
        message(1'b1, 1, 1'b1);
        send(MODE_BEGIN, 1'b0, rnd128(), 5'd0);
        send(MODE_BEGIN, 1'b1, rnd128(), 5'd0);
        send(MODE_END, 1'b1, rnd128(), 5'd0);
        drain();

        count = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            for (int i = 0; i < 4; i++) write_key(i, {$urandom, $urandom});
            while (count < 250 * (ph + 1)) begin
                if ($urandom_range(9) < 8) begin
                    int b;
                    b = $urandom_range(6);
                    message(1'($urandom_range(1)), b, $urandom_range(3) == 0);
                    count += b + 2;
                end else begin
                    send(2'($urandom_range(3)), 1'($urandom_range(1)), rnd128(),
                         5'($urandom_range(31)));
                    count++;
                end
            end
            drain();
        end

        if (sb_q.errors == 0 && sb_q.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
